/* hdl/ctpc_pkg.sv */
// ----------------------------------------------------------------------------
// ctpc_pkg
// Shared types, codes and default sizes of the cut tree packet classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctpc_pkg;

    // default store depths and leaf size
    localparam int NODE_DEPTH_DEF = 4096;
    localparam int LIST_DEPTH_DEF = 4096;
    localparam int RULE_DEPTH_DEF = 1024;
    localparam int LEAF_MAX_DEF   = 16;
    localparam int MAX_LEVELS     = 96;

    // request codes
    localparam logic [2:0] REQ_CLASSIFY = 3'd0;
    localparam logic [2:0] REQ_NODE     = 3'd1;
    localparam logic [2:0] REQ_LIST     = 3'd2;
    localparam logic [2:0] REQ_RULE_LO  = 3'd3;
    localparam logic [2:0] REQ_RULE_HI  = 3'd4;

    // node kinds
    localparam logic [1:0] KIND_INTERNAL = 2'd0;
    localparam logic [1:0] KIND_LEAF     = 2'd1;
    localparam logic [1:0] KIND_EMPTY    = 2'd2;

    // result kinds
    localparam logic [1:0] RES_MATCH     = 2'd0;
    localparam logic [1:0] RES_NO_MATCH  = 2'd1;
    localparam logic [1:0] RES_DEFAULT   = 2'd2;
    localparam logic [1:0] RES_MALFORMED = 2'd3;

    // one queued request
    typedef struct packed {
        logic [2:0]  req_type;
        logic [11:0] index;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [1:0]  node_kind;
        logic [1:0]  cut_field;
        logic [5:0]  cut_bits;
        logic [11:0] link;
        logic [4:0]  leaf_count;
    } t_req;

    // queue handshake toward the back end
    typedef struct packed {
        logic valid;
        t_req req;
    } t_queue_out;

    // one result transaction
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [10:0] rule_number;
        logic [6:0]  levels;
    } t_result;

    // one tree node as stored
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  field;
        logic [5:0]  bits;
        logic [11:0] link;
        logic [4:0]  count;
    } t_node;

    // full width of a header field
    function automatic logic [5:0] field_width(input logic [1:0] f);
        logic [5:0] w;
        w = (f[1] == 1'b0) ? 6'd32 : 6'd16;
        return w;
    endfunction

endpackage

/* hdl/cut_tree_packet_classify_unit.sv */
// ----------------------------------------------------------------------------
// cut_tree_packet_classify_unit
// Decision tree packet classifier: store loading and header lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries requests: classify a
//   header, or write a node, list entry, rule low or rule high bound.
//   Unused request codes are dropped. Writes give no result.
//   Output channel (o_out_valid / i_out_stall) carries one result per
//   classify: kind, one-based rule number and levels walked.
//   Config channel (i_cfg_valid / o_cfg_ready) writes num_rules; write only
//   while the block is idle.
// Flow:
//   Requests pass a two-entry queue. A write is applied as it leaves the
//   queue. A classify reads the single-port node store once per level and
//   reads one list entry and one rule per scanned rule in the back end; it
//   takes no new request until its result is in the output register.
// Reset clears the queue, the walk state, the output register and num_rules;
// the stores keep no reset value. When the receiver stalls, the result holds
// in the output register and the back end waits; the queue keeps accepting
// until full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cut_tree_packet_classify_unit
    import ctpc_pkg::*;
#(
    parameter int NODE_DEPTH = NODE_DEPTH_DEF,
    parameter int LIST_DEPTH = LIST_DEPTH_DEF,
    parameter int RULE_DEPTH = RULE_DEPTH_DEF,
    parameter int LEAF_MAX   = LEAF_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [11:0] i_index,
    input  logic [31:0] i_src_ip,
    input  logic [31:0] i_dst_ip,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic [1:0]  i_node_kind,
    input  logic [1:0]  i_cut_field,
    input  logic [5:0]  i_cut_bits,
    input  logic [11:0] i_link,
    input  logic [4:0]  i_leaf_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_result_kind,
    output logic [10:0] o_rule_number,
    output logic [6:0]  o_levels,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data
);

    t_req       w_req;
    t_queue_out w_queue;
    logic       w_pop;
    t_result    w_out;
    logic [10:0] r_num_rules;

    // gather the request
    assign w_req = '{req_type: i_req_type, index: i_index, src_ip: i_src_ip,
                     dst_ip: i_dst_ip, src_port: i_src_port, dst_port: i_dst_port,
                     node_kind: i_node_kind, cut_field: i_cut_field,
                     cut_bits: i_cut_bits, link: i_link, leaf_count: i_leaf_count};

    // hold the rule count
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rules <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_num_rules <= i_cfg_data;
        end
    end

    ctpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_req   (w_req),
        .i_pop   (w_pop),
        .o_queue (w_queue)
    );

    ctpc_engine #(
        .NODE_DEPTH (NODE_DEPTH),
        .LIST_DEPTH (LIST_DEPTH),
        .RULE_DEPTH (RULE_DEPTH),
        .LEAF_MAX   (LEAF_MAX)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_queue     (w_queue),
        .o_pop       (w_pop),
        .i_num_rules (r_num_rules),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (w_out)
    );

    assign o_result_kind = w_out.result_kind;
    assign o_rule_number = w_out.rule_number;
    assign o_levels      = w_out.levels;

endmodule

/* hdl/ctpc_front.sv */
// ----------------------------------------------------------------------------
// ctpc_front
// Input side: decodes request type, drops unused codes, queues the rest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctpc_front
    import ctpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_req       i_req,
    input  logic       i_pop,
    output t_queue_out o_queue
);

    t_req       r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_keep;

    // keep only codes that mean something
    always_comb begin
        unique case (i_req.req_type)
            REQ_CLASSIFY, REQ_NODE, REQ_LIST, REQ_RULE_LO, REQ_RULE_HI: w_keep = 1'b1;
            default: w_keep = 1'b0;
        endcase
    end

    assign o_stall       = (r_count == 2'd2);
    assign w_push        = i_valid && !o_stall && w_keep;
    assign o_queue.valid = (r_count != 2'd0);
    assign o_queue.req   = r_entry[r_rd_ptr];

    // store payload
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wr_ptr] <= i_req;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, i_pop};
        end
    end

endmodule

/* hdl/ctpc_engine.sv */
// ----------------------------------------------------------------------------
// ctpc_engine
// Back end: loads the stores, walks the tree, scans leaves, holds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctpc_engine
    import ctpc_pkg::*;
#(
    parameter int NODE_DEPTH = NODE_DEPTH_DEF,
    parameter int LIST_DEPTH = LIST_DEPTH_DEF,
    parameter int RULE_DEPTH = RULE_DEPTH_DEF,
    parameter int LEAF_MAX   = LEAF_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_queue_out  i_queue,
    output logic        o_pop,
    input  logic [10:0] i_num_rules,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_result     o_out
);

    localparam int NAW = $clog2(NODE_DEPTH);
    localparam int LAW = $clog2(LIST_DEPTH);
    localparam int RAW = $clog2(RULE_DEPTH);

    localparam logic [16:0] NODE_LIM = 17'(NODE_DEPTH);
    localparam logic [16:0] LIST_LIM = 17'(LIST_DEPTH);
    localparam logic [16:0] RULE_LIM = 17'(RULE_DEPTH);
    localparam logic [7:0]  LEAF_LIM = 8'(LEAF_MAX);
    localparam logic [6:0]  LEVEL_LIM = 7'(MAX_LEVELS);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_NODE_RD  = 3'd1;
    localparam logic [2:0] S_EVAL     = 3'd2;
    localparam logic [2:0] S_CHILD    = 3'd3;
    localparam logic [2:0] S_LIST_RD  = 3'd4;
    localparam logic [2:0] S_LIST_CHK = 3'd5;
    localparam logic [2:0] S_RULE_CMP = 3'd6;
    localparam logic [2:0] S_FIN      = 3'd7;

    // memories
    t_node       node_mem [NODE_DEPTH];
    logic [11:0] list_mem [LIST_DEPTH];
    logic [95:0] lo_mem   [RULE_DEPTH];
    logic [95:0] hi_mem   [RULE_DEPTH];

    logic [2:0]        r_state;
    logic [3:0][31:0]  r_hdr;
    logic [3:0][31:0]  r_low;
    logic [3:0][5:0]   r_left;
    logic [NAW-1:0]    r_addr;
    logic [6:0]        r_levels;
    t_node             r_node;
    logic [31:0]       r_bias;
    logic [5:0]        r_nleft;
    logic [31:0]       r_lo;
    logic [4:0]        r_i;
    logic [10:0]       r_best;
    logic [10:0]       r_cap;
    logic [11:0]       r_list_q;
    logic [11:0]       r_rule_id;
    logic [95:0]       r_rlo;
    logic [95:0]       r_rhi;
    t_result           r_res;
    logic              r_out_valid;
    t_result           r_out;

    logic [16:0]       w_idx;
    logic              w_take;
    logic [1:0]        w_f;
    logic [5:0]        w_left;
    logic [5:0]        w_nleft;
    logic [31:0]       w_diff;
    logic [32:0]       w_child;
    logic [16:0]       w_la;
    logic [16:0]       w_rid;
    logic              w_list_re;
    logic              w_rule_re;
    logic              w_hit;
    logic              w_load_out;
    logic [3:0][31:0]  w_rlo;
    logic [3:0][31:0]  w_rhi;

    assign w_idx      = 17'(i_queue.req.index);
    assign w_take     = (r_state == S_IDLE) && i_queue.valid;
    assign o_pop      = w_take;
    assign w_f        = r_node.field;
    assign w_left     = r_left[w_f];
    assign w_nleft    = w_left - r_node.bits;
    assign w_diff     = r_hdr[w_f] - r_low[w_f];
    assign w_child    = 33'(r_node.link) + 33'(r_bias);
    assign w_la       = 17'(r_node.link) + 17'(r_i);
    assign w_rid      = 17'(r_list_q);
    assign w_list_re  = (r_state == S_LIST_RD) && (w_la < LIST_LIM);
    assign w_rule_re  = (r_state == S_LIST_CHK) && (w_rid < RULE_LIM);
    assign w_load_out = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    // node store
    always_ff @(posedge i_clk) begin
        if (w_take && i_queue.req.req_type == REQ_NODE && w_idx < NODE_LIM) begin
            node_mem[w_idx[NAW-1:0]] <= '{kind: i_queue.req.node_kind,
                                          field: i_queue.req.cut_field,
                                          bits: i_queue.req.cut_bits,
                                          link: i_queue.req.link,
                                          count: i_queue.req.leaf_count};
        end
        r_node <= node_mem[r_addr];
    end

    // list store
    always_ff @(posedge i_clk) begin
        if (w_take && i_queue.req.req_type == REQ_LIST && w_idx < LIST_LIM) begin
            list_mem[w_idx[LAW-1:0]] <= i_queue.req.link;
        end
        if (w_list_re) begin
            r_list_q <= list_mem[w_la[LAW-1:0]];
        end
    end

    // rule low bounds
    always_ff @(posedge i_clk) begin
        if (w_take && i_queue.req.req_type == REQ_RULE_LO && w_idx < RULE_LIM) begin
            lo_mem[w_idx[RAW-1:0]] <= {i_queue.req.src_ip, i_queue.req.dst_ip,
                                       i_queue.req.src_port, i_queue.req.dst_port};
        end
        if (w_rule_re) begin
            r_rlo <= lo_mem[w_rid[RAW-1:0]];
        end
    end

    // rule high bounds
    always_ff @(posedge i_clk) begin
        if (w_take && i_queue.req.req_type == REQ_RULE_HI && w_idx < RULE_LIM) begin
            hi_mem[w_idx[RAW-1:0]] <= {i_queue.req.src_ip, i_queue.req.dst_ip,
                                       i_queue.req.src_port, i_queue.req.dst_port};
        end
        if (w_rule_re) begin
            r_rhi <= hi_mem[w_rid[RAW-1:0]];
        end
    end

    // unpack bounds and range-check the header
    always_comb begin
        w_rlo[0] = r_rlo[95:64];
        w_rlo[1] = r_rlo[63:32];
        w_rlo[2] = {16'd0, r_rlo[31:16]};
        w_rlo[3] = {16'd0, r_rlo[15:0]};
        w_rhi[0] = r_rhi[95:64];
        w_rhi[1] = r_rhi[63:32];
        w_rhi[2] = {16'd0, r_rhi[31:16]};
        w_rhi[3] = {16'd0, r_rhi[15:0]};
        w_hit    = 1'b1;
        for (int f = 0; f < 4; f++) begin
            if (r_hdr[f] < w_rlo[f] || r_hdr[f] > w_rhi[f]) begin
                w_hit = 1'b0;
            end
        end
    end

    // sequence the walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_take && i_queue.req.req_type == REQ_CLASSIFY) begin
                        r_hdr[0] <= i_queue.req.src_ip;
                        r_hdr[1] <= i_queue.req.dst_ip;
                        r_hdr[2] <= {16'd0, i_queue.req.src_port};
                        r_hdr[3] <= {16'd0, i_queue.req.dst_port};
                        for (int f = 0; f < 4; f++) begin
                            r_low[f]  <= '0;
                            r_left[f] <= field_width(2'(f));
                        end
                        r_addr   <= '0;
                        r_levels <= '0;
                        r_cap    <= (17'(i_num_rules) > RULE_LIM) ? 11'(RULE_LIM)
                                                                  : i_num_rules;
                        r_state  <= S_NODE_RD;
                    end
                end
                S_NODE_RD: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_res.levels      <= r_levels;
                    r_res.rule_number <= '0;
                    r_res.result_kind <= RES_MALFORMED;
                    unique case (r_node.kind)
                        KIND_INTERNAL: begin
                            if (r_levels >= LEVEL_LIM || r_node.bits > w_left) begin
                                r_state <= S_FIN;
                            end else begin
                                r_nleft <= w_nleft;
                                r_bias  <= w_diff >> w_nleft;
                                r_lo    <= (r_hdr[w_f] >> w_nleft) << w_nleft;
                                r_state <= S_CHILD;
                            end
                        end
                        KIND_LEAF: begin
                            r_best <= r_cap;
                            r_i    <= '0;
                            if ({3'd0, r_node.count} > LEAF_LIM) begin
                                r_state <= S_FIN;
                            end else if (r_node.count == 5'd0) begin
                                r_res.result_kind <= RES_NO_MATCH;
                                r_res.rule_number <= r_cap + 11'd1;
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_LIST_RD;
                            end
                        end
                        KIND_EMPTY: begin
                            r_res.result_kind <= RES_DEFAULT;
                            r_state <= S_FIN;
                        end
                        default: begin
                            r_state <= S_FIN;
                        end
                    endcase
                end
                S_CHILD: begin
                    if (w_child >= 33'(NODE_LIM)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_low[w_f]  <= r_lo;
                        r_left[w_f] <= r_nleft;
                        r_levels    <= r_levels + 7'd1;
                        r_addr      <= w_child[NAW-1:0];
                        r_state     <= S_NODE_RD;
                    end
                end
                S_LIST_RD: begin
                    r_state <= w_list_re ? S_LIST_CHK : S_FIN;
                end
                S_LIST_CHK: begin
                    r_rule_id <= r_list_q;
                    r_state   <= w_rule_re ? S_RULE_CMP : S_FIN;
                end
                S_RULE_CMP: begin
                    logic [10:0] best;
                    best = (w_hit && r_rule_id < {1'b0, r_best}) ? 11'(r_rule_id) : r_best;
                    r_best <= best;
                    r_i    <= r_i + 5'd1;
                    if (r_i + 5'd1 == r_node.count) begin
                        r_res.result_kind <= (best < r_cap) ? RES_MATCH : RES_NO_MATCH;
                        r_res.rule_number <= best + 11'd1;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_LIST_RD;
                    end
                end
                S_FIN: begin
                    if (w_load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* hdl/ctpc_checker.sv */
// ----------------------------------------------------------------------------
// ctpc_assertions
// Port-level checks of the classifier result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctpc_assertions
    import ctpc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_result_kind,
    input logic [10:0] o_rule_number,
    input logic [6:0]  o_levels
);

    // hold a stalled transaction
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_rule_number))
        else $error("stalled result dropped or changed");

    // default and malformed carry no rule number
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == RES_DEFAULT || o_result_kind == RES_MALFORMED)
        |-> o_rule_number == 11'd0)
        else $error("rule number on default or malformed result");

    // a match result names a rule
    a_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == RES_MATCH) |-> o_rule_number != 11'd0)
        else $error("match without rule number");

    // walk depth bounded
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_levels <= 7'(MAX_LEVELS))
        else $error("levels beyond limit");

endmodule

bind cut_tree_packet_classify_unit ctpc_assertions u_ctpc_assertions (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_result_kind (o_result_kind),
    .o_rule_number (o_rule_number),
    .o_levels      (o_levels)
);

/* tb/ctpc_checker.sv */
// ----------------------------------------------------------------------------
// ctpc_checker
// Watches the request, result and config channels of the cut tree classifier,
// keeps its own copy of the stores and num_rules, predicts every classify
// result and compares each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctpc_checker
    import ctpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [11:0] i_index,
    input  logic [31:0] i_src_ip,
    input  logic [31:0] i_dst_ip,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic [1:0]  i_node_kind,
    input  logic [1:0]  i_cut_field,
    input  logic [5:0]  i_cut_bits,
    input  logic [11:0] i_link,
    input  logic [4:0]  i_leaf_count,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_result_kind,
    input  logic [10:0] i_rule_number,
    input  logic [6:0]  i_levels,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [10:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    t_node       tree_nodes [NODE_DEPTH_DEF];
    logic [11:0] rule_ids   [LIST_DEPTH_DEF];
    logic [63:0] ip_lows    [RULE_DEPTH_DEF];
    logic [31:0] port_lows  [RULE_DEPTH_DEF];
    logic [63:0] ip_highs   [RULE_DEPTH_DEF];
    logic [31:0] port_highs [RULE_DEPTH_DEF];
    logic [10:0] rule_count;
    t_result     expected_results [$];

    assign o_pending = expected_results.size();

    // check one rule's four ranges against the header
    function automatic bit rule_covers(int r, logic [31:0] hdr [4]);
        logic [31:0] lo [4];
        logic [31:0] hi [4];
        lo[0] = ip_lows[r][63:32];    hi[0] = ip_highs[r][63:32];
        lo[1] = ip_lows[r][31:0];     hi[1] = ip_highs[r][31:0];
        lo[2] = port_lows[r][31:16];  hi[2] = port_highs[r][31:16];
        lo[3] = port_lows[r][15:0];   hi[3] = port_highs[r][15:0];
        for (int f = 0; f < 4; f++) begin
            if (hdr[f] < lo[f] || hdr[f] > hi[f]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // walk the tree for one header
    function automatic t_result walk_tree(logic [31:0] hdr [4]);
        t_result     res;
        logic [31:0] lows [4];
        int          bits_left [4];
        int          addr, depth, cap, best, nleft, la, r;
        logic [63:0] bias, child;
        t_node       nd;
        bit          bad;
        res = '{result_kind: RES_MALFORMED, rule_number: 11'd0, levels: 7'd0};
        for (int f = 0; f < 4; f++) begin
            lows[f] = 32'd0;
            bits_left[f] = (f < 2) ? 32 : 16;
        end
        addr = 0;
        depth = 0;
        cap = (rule_count > RULE_DEPTH_DEF) ? RULE_DEPTH_DEF : int'(rule_count);
        forever begin
            nd = tree_nodes[addr];
            if (nd.kind == KIND_INTERNAL) begin
                if (depth >= MAX_LEVELS) break;
                if (int'(nd.bits) > bits_left[nd.field]) break;
                nleft = bits_left[nd.field] - int'(nd.bits);
                bias = ({32'd0, hdr[nd.field]} - {32'd0, lows[nd.field]}) >> nleft;
                child = {52'd0, nd.link} + bias;
                if (child >= NODE_DEPTH_DEF) break;
                lows[nd.field] = 32'(({32'd0, hdr[nd.field]} >> nleft) << nleft);
                bits_left[nd.field] = nleft;
                depth++;
                addr = int'(child);
            end else if (nd.kind == KIND_LEAF) begin
                if (nd.count > LEAF_MAX_DEF) break;
                bad = 1'b0;
                best = cap;
                for (int i = 0; i < nd.count; i++) begin
                    la = int'(nd.link) + i;
                    if (la >= LIST_DEPTH_DEF) begin
                        bad = 1'b1;
                        break;
                    end
                    r = int'(rule_ids[la]);
                    if (r >= RULE_DEPTH_DEF) begin
                        bad = 1'b1;
                        break;
                    end
                    if (rule_covers(r, hdr) && r < best) best = r;
                end
                if (bad) break;
                res.result_kind = (best < cap) ? RES_MATCH : RES_NO_MATCH;
                res.rule_number = 11'(best + 1);
                break;
            end else if (nd.kind == KIND_EMPTY) begin
                res.result_kind = RES_DEFAULT;
                break;
            end else begin
                break;
            end
        end
        res.levels = 7'(depth);
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] checker: %s", $realtime, msg);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        logic [31:0] hdr [4];
        t_result     want;
        if (!i_rst_n) begin
            rule_count = 11'd0;
            expected_results.delete();
        end else begin
            // capture config transactions
            if (i_cfg_valid && i_cfg_ready) rule_count = i_cfg_data;
            // apply or predict each accepted request
            if (i_in_valid && !i_in_stall) begin
                hdr[0] = i_src_ip;
                hdr[1] = i_dst_ip;
                hdr[2] = 32'(i_src_port);
                hdr[3] = 32'(i_dst_port);
                case (i_req_type)
                    REQ_CLASSIFY: expected_results.push_back(walk_tree(hdr));
                    REQ_NODE: tree_nodes[i_index] = '{kind: i_node_kind,
                        field: i_cut_field, bits: i_cut_bits, link: i_link,
                        count: i_leaf_count};
                    REQ_LIST: rule_ids[i_index] = i_link;
                    REQ_RULE_LO: if (i_index < RULE_DEPTH_DEF) begin
                        ip_lows[i_index] = {i_src_ip, i_dst_ip};
                        port_lows[i_index] = {i_src_port, i_dst_port};
                    end
                    REQ_RULE_HI: if (i_index < RULE_DEPTH_DEF) begin
                        ip_highs[i_index] = {i_src_ip, i_dst_ip};
                        port_highs[i_index] = {i_src_port, i_dst_port};
                    end
                    default: ;
                endcase
            end
            // compare result transactions
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no prediction waiting");
                end else begin
                    want = expected_results.pop_front();
                    if (i_result_kind !== want.result_kind || i_rule_number !==
                        want.rule_number || i_levels !== want.levels)
                        report_mismatch($sformatf(
                            "got kind %0d rule %0d levels %0d, want %0d %0d %0d",
                            i_result_kind, i_rule_number, i_levels,
                            want.result_kind, want.rule_number, want.levels));
                end
            end
        end
    end

endmodule

/* tb/cut_tree_packet_classify_unit_tb.sv */
// ----------------------------------------------------------------------------
// cut_tree_packet_classify_unit_tb
// Loads the used part of every store, runs directed lookups over the special
// cases of the walk and leaf scan, then random store writes and headers under
// several num_rules settings, with random idling and stalls. The checker
// predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cut_tree_packet_classify_unit_tb;
    import ctpc_pkg::*;

    // loaded regions: every lookup stays inside these or runs out of range
    localparam int TREE_NODES    = 128;
    localparam int LIST_LOW      = 256;
    localparam int LIST_TOP_BASE = 4080;
    localparam int RULES_LOADED  = 128;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_req_type = '0;
    logic [11:0] i_index = '0;
    logic [31:0] i_src_ip = '0;
    logic [31:0] i_dst_ip = '0;
    logic [15:0] i_src_port = '0;
    logic [15:0] i_dst_port = '0;
    logic [1:0]  i_node_kind = '0;
    logic [1:0]  i_cut_field = '0;
    logic [5:0]  i_cut_bits = '0;
    logic [11:0] i_link = '0;
    logic [4:0]  i_leaf_count = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_result_kind;
    logic [10:0] o_rule_number;
    logic [6:0]  o_levels;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data = '0;
    int          fail_count;
    int          pending;
    bit          idle_on = 1'b0;

    always #6 i_clk = ~i_clk;

    cut_tree_packet_classify_unit u_top (.*);

    ctpc_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_req_type,
        .i_index, .i_src_ip, .i_dst_ip, .i_src_port, .i_dst_port, .i_node_kind,
        .i_cut_field, .i_cut_bits, .i_link, .i_leaf_count,
        .i_out_valid(o_out_valid), .i_out_stall, .i_result_kind(o_result_kind),
        .i_rule_number(o_rule_number), .i_levels(o_levels), .i_cfg_valid,
        .i_cfg_ready(o_cfg_ready), .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // random receiver stall
    always @(negedge i_clk) begin
        i_out_stall = idle_on && ($urandom_range(0, 99) < 20);
    end

    // drive one request and hold it until accepted
    task automatic send_req(t_req rq);
        @(negedge i_clk);
        i_in_valid   = 1'b1;
        i_req_type   = rq.req_type;
        i_index      = rq.index;
        i_src_ip     = rq.src_ip;
        i_dst_ip     = rq.dst_ip;
        i_src_port   = rq.src_port;
        i_dst_port   = rq.dst_port;
        i_node_kind  = rq.node_kind;
        i_cut_field  = rq.cut_field;
        i_cut_bits   = rq.cut_bits;
        i_link       = rq.link;
        i_leaf_count = rq.leaf_count;
        do @(posedge i_clk); while (o_in_stall);
        if (idle_on && $urandom_range(0, 99) < 20) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge i_clk);
        end
    endtask

    task automatic drain_block();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (pending == 0);
        repeat (20) @(negedge i_clk);
    endtask

    // write num_rules while idle
    task automatic set_rule_count(logic [10:0] value);
        drain_block();
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic t_req node_req(int idx, logic [1:0] kind, logic [1:0] fld,
                                      int bits, int lnk, int cnt);
        t_req rq;
        rq = '0;
        rq.req_type = REQ_NODE;
        rq.index = 12'(idx);
        rq.node_kind = kind;
        rq.cut_field = fld;
        rq.cut_bits = 6'(bits);
        rq.link = 12'(lnk);
        rq.leaf_count = 5'(cnt);
        return rq;
    endfunction

    function automatic t_req header_req(logic [31:0] sip, logic [31:0] dip,
                                        logic [15:0] sp, logic [15:0] dp);
        t_req rq;
        rq = '0;
        rq.req_type = REQ_CLASSIFY;
        rq.src_ip = sip;
        rq.dst_ip = dip;
        rq.src_port = sp;
        rq.dst_port = dp;
        return rq;
    endfunction

    // rule bound: random low edge with leading zero bits or high edge with leading one bits
    function automatic t_req rule_req(int idx, bit high);
        t_req rq;
        int   sh;
        rq = '0;
        rq.req_type = high ? REQ_RULE_HI : REQ_RULE_LO;
        rq.index = 12'(idx);
        sh = $urandom_range(0, 32);
        rq.src_ip = high ? ~(32'($urandom) >> sh) : (32'($urandom) >> sh);
        sh = $urandom_range(0, 32);
        rq.dst_ip = high ? ~(32'($urandom) >> sh) : (32'($urandom) >> sh);
        sh = $urandom_range(0, 16);
        rq.src_port = high ? ~(16'($urandom) >> sh) : (16'($urandom) >> sh);
        sh = $urandom_range(0, 16);
        rq.dst_port = high ? ~(16'($urandom) >> sh) : (16'($urandom) >> sh);
        return rq;
    endfunction

    function automatic logic [31:0] rand_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 32'd0;
        if (pick == 1) return 32'hffff_ffff;
        return 32'($urandom);
    endfunction

    // keep children and list reads inside the loaded regions or past the end
    function automatic t_req random_req();
        t_req       rq;
        int         pick;
        int         idx;
        int         bits;
        int         lnk;
        int         cnt;
        logic [1:0] kind;
        rq = '0;
        bits = 0;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            rq = header_req(rand_word(), rand_word(), 16'(rand_word()),
                            16'(rand_word()));
        end else if (pick < 65) begin
            kind = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                              : $urandom_range(0, TREE_NODES - 1);
            if (kind == KIND_INTERNAL) begin
                if ($urandom_range(0, 9) == 0) begin
                    bits = $urandom_range(0, 63);
                    lnk = 4095;
                end else begin
                    bits = $urandom_range(0, 4);
                    lnk = $urandom_range(0, TREE_NODES - 17);
                end
            end else begin
                lnk = ($urandom_range(0, 9) == 0) ? $urandom_range(LIST_TOP_BASE + 5, 4095)
                                                  : $urandom_range(0, LIST_LOW - 17);
            end
            cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                              : $urandom_range(0, 16);
            rq = node_req(idx, kind, 2'($urandom), bits, lnk, cnt);
        end else if (pick < 80) begin
            rq.req_type = REQ_LIST;
            rq.index = 12'($urandom);
            rq.link = 12'(($urandom_range(0, 19) == 0) ? $urandom_range(1024, 4095)
                                                       : $urandom_range(0, RULES_LOADED - 1));
        end else if (pick < 97) begin
            rq = rule_req(($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                      : $urandom_range(0, RULES_LOADED - 1),
                          pick >= 88);
        end else begin
            rq = header_req(rand_word(), rand_word(), 16'(rand_word()),
                            16'(rand_word()));
            rq.req_type = 3'($urandom_range(5, 7));
        end
        return rq;
    endfunction

    // stimulus
    initial begin
        t_req rq;
        int   ok_ids;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        set_rule_count(11'd1024);

        // load the used regions so no lookup reads an unwritten entry
        for (int r = 0; r < RULES_LOADED; r++) begin
            send_req(rule_req(r, 1'b0));
            send_req(rule_req(r, 1'b1));
        end
        for (int a = 0; a < 4096; a++) begin
            if (a < LIST_LOW || a >= LIST_TOP_BASE) begin
                rq = '0;
                rq.req_type = REQ_LIST;
                rq.index = 12'(a);
                rq.link = 12'($urandom_range(0, RULES_LOADED - 1));
                send_req(rq);
            end
        end
        for (int n = 0; n < TREE_NODES; n++)
            send_req(node_req(n, KIND_LEAF, 2'd0, 0, $urandom_range(0, LIST_LOW - 17),
                              $urandom_range(0, 16)));
        send_req(node_req(4095, KIND_LEAF, 2'd0, 0, $urandom_range(0, LIST_LOW - 17),
                          $urandom_range(0, 16)));
        idle_on = 1'b1;

        // directed: cut, leaves, empty, bad kind, deep cut, loops, bounds
        send_req(node_req(0, KIND_INTERNAL, 2'd0, 3, 100, 0));
        send_req(node_req(100, KIND_LEAF, 2'd0, 0, 0, 16));
        send_req(node_req(101, KIND_EMPTY, 2'd0, 0, 0, 0));
        send_req(node_req(102, KIND_INTERNAL, 2'd0, 30, 0, 0));
        send_req(node_req(103, 2'd3, 2'd0, 0, 0, 0));
        send_req(node_req(104, KIND_INTERNAL, 2'd3, 0, 104, 0));
        send_req(node_req(105, KIND_INTERNAL, 2'd2, 1, 4095, 0));
        send_req(node_req(106, KIND_LEAF, 2'd0, 0, 4090, 16));
        send_req(node_req(107, KIND_LEAF, 2'd0, 0, 10, 17));
        send_req(node_req(108, KIND_LEAF, 2'd0, 0, 10, 0));
        rq = '0;
        rq.req_type = REQ_LIST;
        rq.index = 12'd4093;
        rq.link = 12'd4095;
        send_req(rq);
        for (int s = 0; s < 8; s++)
            send_req(header_req({3'(s), 29'h1fff_ffff}, 32'hffff_ffff,
                                16'hffff, 16'hffff));
        send_req(header_req(32'd0, 32'd0, 16'd0, 16'd0));
        rq = header_req(32'd0, 32'd0, 16'd0, 16'd0);
        rq.req_type = 3'd7;
        send_req(rq);
        rq = rule_req(4095, 1'b1);
        send_req(rq);

        // random phases across num_rules settings
        for (int k = 0; k < 920; k++) begin
            if (k % 184 == 0) begin
                case (k / 184)
                    0: set_rule_count(11'd0);
                    1: set_rule_count(11'd2047);
                    2: set_rule_count(11'($urandom_range(1, 160)));
                    3: set_rule_count(11'd1024);
                    default: set_rule_count(11'($urandom_range(1025, 2046)));
                endcase
            end
            idle_on = !(k >= 350 && k < 520);
            if (k == 600) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                wait (pending == 0);
            end
            send_req(random_req());
        end

        // drain
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (pending == 0);
        repeat (500) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #80_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
